/* rtl/core/spq_pkg.sv */
`timescale 1ns / 1ps

package spq_pkg;

    localparam logic [1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [1:0] CMD_QUERY   = 2'd2;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    typedef struct packed {
        logic [1:0]                command;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] removed_value;
        logic                      removed_valid;
        logic                      empty_error;
        logic                      full_drop;
        logic signed [VALUE_W-1:0] front_value;
        logic signed [VALUE_W-1:0] rear_value;
        logic [COUNT_W-1:0]        entry_count;
        logic                      queue_empty;
    } rsp_t;

    // Per-cycle operation broadcast to every cell.
    typedef struct packed {
        logic ins;
        logic del;
    } cell_ctrl_t;

endpackage

/* rtl/core/spq_cell.sv */
`timescale 1ns / 1ps

module spq_cell
(
    input  logic                               clk,
    input  spq_pkg::cell_ctrl_t                ctrl,
    input  logic signed [spq_pkg::VALUE_W-1:0] value,
    input  logic                               occupied,
    input  logic                               at_tail,
    input  logic                               prev_shift,
    input  logic signed [spq_pkg::VALUE_W-1:0] prev_entry,
    input  logic signed [spq_pkg::VALUE_W-1:0] next_entry,
    output logic                               shift,
    output logic signed [spq_pkg::VALUE_W-1:0] entry,
    output logic signed [spq_pkg::VALUE_W-1:0] entry_next
);

    logic signed [spq_pkg::VALUE_W-1:0] entry_reg;

    // Strict compare: equal values stay ahead of the new one.
    assign shift = occupied && (value < entry_reg);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (prev_shift)
            begin
                entry_next = prev_entry;
            end
            else if (shift || at_tail)
            begin
                entry_next = value;
            end
        end
        else if (ctrl.del)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* rtl/core/sorted_priority_queue_top.sv */
`timescale 1ns / 1ps

// Sorted min-priority queue of up to CAPACITY signed 32-bit values, held in
// ascending order in a row of cells that each compare the incoming value
// against their own entry and shift toward their neighbor. Every item
// (enqueue, dequeue, query or unused command) yields exactly one result,
// so an item is accepted in every cycle while the result side takes them;
// the result register holds a result until it is taken, and req_stall is
// high only while that register is full and stalled. The compare-and-shift
// across the cell row sets the cycle time.

module sorted_priority_queue_top
#(
    parameter int CAPACITY = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  spq_pkg::req_t   req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output spq_pkg::rsp_t   rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VW = spq_pkg::VALUE_W;

    logic                 accept;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic signed [VW-1:0] rear_reg;
    logic signed [VW-1:0] rear_next;
    logic                 rsp_valid_reg;
    spq_pkg::rsp_t        rsp_reg;
    spq_pkg::rsp_t        rsp_next;
    spq_pkg::cell_ctrl_t  ctrl;
    logic                 is_enq;
    logic                 is_deq;
    logic                 full;
    logic                 empty;
    logic [CW+4:0]        count_wide;

    logic                 shift      [CAPACITY];
    logic signed [VW-1:0] entry      [CAPACITY];
    logic signed [VW-1:0] entry_next [CAPACITY];

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);

    always_comb
    begin
        is_enq = 1'b0;
        is_deq = 1'b0;
        unique case (req.command)
            spq_pkg::CMD_ENQUEUE: is_enq = 1'b1;
            spq_pkg::CMD_DEQUEUE: is_deq = 1'b1;
            default:              ;
        endcase
    end

    assign ctrl.ins = accept && is_enq && !full;
    assign ctrl.del = accept && is_deq && !empty;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            spq_cell u_cell
            (
                .clk        (clk),
                .ctrl       (ctrl),
                .value      (req.value),
                .occupied   (count_reg > CW'(i)),
                .at_tail    (count_reg == CW'(i)),
                .prev_shift ((i == 0) ? 1'b0 : shift[(i == 0) ? 0 : i - 1]),
                .prev_entry (entry[(i == 0) ? 0 : i - 1]),
                .next_entry (entry[(i == CAPACITY - 1) ? i : i + 1]),
                .shift      (shift[i]),
                .entry      (entry[i]),
                .entry_next (entry_next[i])
            );
        end
    endgenerate

    // Track the largest entry beside the row so no indexed read is needed.
    always_comb
    begin
        count_next = count_reg;
        rear_next  = rear_reg;
        if (ctrl.ins)
        begin
            count_next = count_reg + CW'(1);
            if (empty || !(req.value < rear_reg))
            begin
                rear_next = req.value;
            end
        end
        else if (ctrl.del)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign count_wide = {5'b0, count_next};

    always_comb
    begin
        rsp_next.removed_value = ctrl.del ? entry[0] : '0;
        rsp_next.removed_valid = ctrl.del;
        rsp_next.empty_error   = is_deq && empty;
        rsp_next.full_drop     = is_enq && full;
        rsp_next.front_value   = (count_next == '0) ? '0 : entry_next[0];
        rsp_next.rear_value    = (count_next == '0) ? '0 : rear_next;
        rsp_next.entry_count   = count_wide[4:0];
        rsp_next.queue_empty   = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rear_reg <= rear_next;
            rsp_reg  <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* rtl/core/spq_checker.sv */
`timescale 1ns / 1ps

module spq_checker
#(
    parameter int CAPACITY = 16
)
(
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input spq_pkg::rsp_t rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW+4:0] cap_wide;

    assign cap_wide = {5'b0, CW'(CAPACITY)};

    // Every accepted item shows its result on the next cycle.
    a_accept_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> rsp_valid)
        else $error("accepted item without result");

    // The input stalls only behind a waiting, stalled result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_valid && rsp_stall))
        else $error("input stalled without waiting result");

    // A dropped enqueue leaves a full queue behind.
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.full_drop) |-> (rsp.entry_count == cap_wide[4:0]))
        else $error("drop without full queue");

    // An empty error leaves an empty queue behind and removes nothing.
    a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.empty_error) |-> (rsp.queue_empty && !rsp.removed_valid))
        else $error("empty error on nonempty queue");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled result changed");

endmodule

bind sorted_priority_queue_top spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

/* tb/sv/sorted_priority_queue_top_tb.sv */
`timescale 1ns / 1ps

module sorted_priority_queue_top_tb;

    localparam int CAPACITY      = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 10;
    localparam int PHASE_ITEMS   = 250;
    localparam int BIAS_STRETCH  = 40;

    localparam logic [1:0]         CMD_UNUSED = 2'd3;
    localparam logic signed [31:0] VAL_MAX    = 32'sh7fff_ffff;
    localparam logic signed [31:0] VAL_MIN    = 32'sh8000_0000;

    typedef struct {
        spq_pkg::req_t item;
        bit            typed;
        spq_pkg::rsp_t rsp;
    } directed_row_t;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_stall;
    spq_pkg::req_t  req;
    logic           rsp_valid;
    logic           rsp_stall;
    spq_pkg::rsp_t  rsp;

    // Queue model state
    logic signed [spq_pkg::VALUE_W-1:0] queue_entries [CAPACITY];
    int                                 queue_count;

    spq_pkg::rsp_t pending_rsps [$];
    directed_row_t directed_rows [$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_pending;
    int          fail_count;
    int          cycle_count;

    sorted_priority_queue_top #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic spq_pkg::rsp_t make_rsp(
        input logic signed [31:0] removed_value,
        input logic               removed_valid,
        input logic               empty_error,
        input logic               full_drop,
        input logic signed [31:0] front_value,
        input logic signed [31:0] rear_value,
        input logic [4:0]         entry_count,
        input logic               queue_empty
    );
        spq_pkg::rsp_t r;
        r.removed_value = removed_value;
        r.removed_valid = removed_valid;
        r.empty_error   = empty_error;
        r.full_drop     = full_drop;
        r.front_value   = front_value;
        r.rear_value    = rear_value;
        r.entry_count   = entry_count;
        r.queue_empty   = queue_empty;
        return r;
    endfunction

    function automatic directed_row_t make_row(
        input logic [1:0]         command,
        input logic signed [31:0] value,
        input bit                 typed,
        input spq_pkg::rsp_t      rsp_typed
    );
        directed_row_t row;
        row.item.command = command;
        row.item.value   = value;
        row.typed        = typed;
        row.rsp          = rsp_typed;
        return row;
    endfunction

    // Apply one command to the queue model and return the result it yields.
    function automatic spq_pkg::rsp_t predict_step(input spq_pkg::req_t item);
        spq_pkg::rsp_t                      r;
        int                                 pos;
        int                                 i;
        logic signed [spq_pkg::VALUE_W-1:0] v;
        r = '0;
        v = $signed(item.value);
        if (item.command == spq_pkg::CMD_ENQUEUE)
        begin
            if (queue_count >= CAPACITY)
            begin
                r.full_drop = 1'b1;
            end
            else
            begin
                // Equal values go after those already stored
                pos = 0;
                while (pos < queue_count && !(v < queue_entries[pos]))
                    pos++;
                for (i = queue_count; i > pos; i--)
                    queue_entries[i] = queue_entries[i-1];
                queue_entries[pos] = v;
                queue_count++;
            end
        end
        else if (item.command == spq_pkg::CMD_DEQUEUE)
        begin
            if (queue_count == 0)
            begin
                r.empty_error = 1'b1;
            end
            else
            begin
                r.removed_value = queue_entries[0];
                r.removed_valid = 1'b1;
                for (i = 1; i < queue_count; i++)
                    queue_entries[i-1] = queue_entries[i];
                queue_count--;
            end
        end
        if (queue_count != 0)
        begin
            r.front_value = queue_entries[0];
            r.rear_value  = queue_entries[queue_count-1];
        end
        r.entry_count = queue_count[spq_pkg::COUNT_W-1:0];
        r.queue_empty = (queue_count == 0);
        return r;
    endfunction

    function automatic spq_pkg::req_t random_request(input bit fill_bias);
        spq_pkg::req_t r;
        int unsigned   pick;
        pick = $urandom_range(99);
        if (pick < 4)
            r.command = CMD_UNUSED;
        else if (pick < 12)
            r.command = spq_pkg::CMD_QUERY;
        else if (pick < (fill_bias ? 70 : 35))
            r.command = spq_pkg::CMD_ENQUEUE;
        else
            r.command = spq_pkg::CMD_DEQUEUE;
        case ($urandom_range(3))
            0: r.value = $signed($urandom_range(15)) - 8;  // many duplicates
            1: r.value = $urandom_range(1) ? VAL_MAX : VAL_MIN;
            default: r.value = $urandom;
        endcase
        return r;
    endfunction

    task automatic send_item(input spq_pkg::req_t item, input bit typed,
                             input spq_pkg::rsp_t rsp_typed);
        spq_pkg::rsp_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        predicted = predict_step(item);
        pending_rsps.push_back(typed ? rsp_typed : predicted);
    endtask

    task automatic check_result(input spq_pkg::rsp_t exp, input spq_pkg::rsp_t act);
        if (act.removed_value !== exp.removed_value)
        begin
            $error("removed_value: expected %0d, actual %0d", exp.removed_value,
                   act.removed_value);
            fail_count++;
        end
        if (act.removed_valid !== exp.removed_valid)
        begin
            $error("removed_valid: expected %0b, actual %0b", exp.removed_valid,
                   act.removed_valid);
            fail_count++;
        end
        if (act.empty_error !== exp.empty_error)
        begin
            $error("empty_error: expected %0b, actual %0b", exp.empty_error,
                   act.empty_error);
            fail_count++;
        end
        if (act.full_drop !== exp.full_drop)
        begin
            $error("full_drop: expected %0b, actual %0b", exp.full_drop, act.full_drop);
            fail_count++;
        end
        if (act.front_value !== exp.front_value)
        begin
            $error("front_value: expected %0d, actual %0d", exp.front_value,
                   act.front_value);
            fail_count++;
        end
        if (act.rear_value !== exp.rear_value)
        begin
            $error("rear_value: expected %0d, actual %0d", exp.rear_value, act.rear_value);
            fail_count++;
        end
        if (act.entry_count !== exp.entry_count)
        begin
            $error("entry_count: expected %0d, actual %0d", exp.entry_count,
                   act.entry_count);
            fail_count++;
        end
        if (act.queue_empty !== exp.queue_empty)
        begin
            $error("queue_empty: expected %0b, actual %0b", exp.queue_empty,
                   act.queue_empty);
            fail_count++;
        end
    endtask

    // Result side: take results and compare with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsps.size() == 0)
            begin
                $error("result with no item waiting for it");
                fail_count++;
            end
            else
            begin
                check_result(pending_rsps.pop_front(), rsp);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result stall; a requested hold keeps the stall up for a long stretch
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_pending = 1'b0;
            end
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        send_idle_pct = 32;
        recv_idle_pct = 81;
        hold_pending  = 1'b0;
        fail_count    = 0;
        cycle_count   = 0;
        queue_count   = 0;
        for (int i = 0; i < CAPACITY; i++)
            queue_entries[i] = '0;

        // Empty queue, extremes, duplicates, fill to full and overflow
        directed_rows.push_back(make_row(spq_pkg::CMD_QUERY, 32'sd0, 1'b1,
            make_rsp(32'sd0, 1'b0, 1'b0, 1'b0, 32'sd0, 32'sd0, 5'd0, 1'b1)));
        directed_rows.push_back(make_row(spq_pkg::CMD_DEQUEUE, 32'sd0, 1'b1,
            make_rsp(32'sd0, 1'b0, 1'b1, 1'b0, 32'sd0, 32'sd0, 5'd0, 1'b1)));
        directed_rows.push_back(make_row(CMD_UNUSED, -32'sd1, 1'b1,
            make_rsp(32'sd0, 1'b0, 1'b0, 1'b0, 32'sd0, 32'sd0, 5'd0, 1'b1)));
        directed_rows.push_back(make_row(spq_pkg::CMD_ENQUEUE, VAL_MAX, 1'b1,
            make_rsp(32'sd0, 1'b0, 1'b0, 1'b0, VAL_MAX, VAL_MAX, 5'd1, 1'b0)));
        directed_rows.push_back(make_row(spq_pkg::CMD_ENQUEUE, VAL_MIN, 1'b1,
            make_rsp(32'sd0, 1'b0, 1'b0, 1'b0, VAL_MIN, VAL_MAX, 5'd2, 1'b0)));
        directed_rows.push_back(make_row(spq_pkg::CMD_ENQUEUE, 32'sd0, 1'b0, '0));
        directed_rows.push_back(make_row(spq_pkg::CMD_ENQUEUE, -32'sd1, 1'b0, '0));
        directed_rows.push_back(make_row(spq_pkg::CMD_ENQUEUE, 32'sd0, 1'b0, '0));
        directed_rows.push_back(make_row(spq_pkg::CMD_DEQUEUE, VAL_MAX, 1'b0, '0));
        directed_rows.push_back(make_row(spq_pkg::CMD_ENQUEUE, 32'sd5, 1'b0, '0));
        directed_rows.push_back(make_row(spq_pkg::CMD_ENQUEUE, -32'sd5, 1'b0, '0));
        directed_rows.push_back(make_row(spq_pkg::CMD_ENQUEUE, VAL_MAX, 1'b0, '0));
        directed_rows.push_back(make_row(spq_pkg::CMD_ENQUEUE, VAL_MIN, 1'b0, '0));
        directed_rows.push_back(make_row(spq_pkg::CMD_ENQUEUE, 32'sd5, 1'b0, '0));
        directed_rows.push_back(make_row(spq_pkg::CMD_ENQUEUE, 32'sd100, 1'b0, '0));
        directed_rows.push_back(make_row(spq_pkg::CMD_ENQUEUE, -32'sd100, 1'b0, '0));
        directed_rows.push_back(make_row(spq_pkg::CMD_ENQUEUE, 32'sd0, 1'b0, '0));
        directed_rows.push_back(make_row(spq_pkg::CMD_ENQUEUE, 32'sh5555_5555, 1'b0, '0));
        directed_rows.push_back(make_row(spq_pkg::CMD_ENQUEUE, 32'shaaaa_aaaa, 1'b0, '0));
        directed_rows.push_back(make_row(spq_pkg::CMD_ENQUEUE, 32'sd1, 1'b0, '0));
        directed_rows.push_back(make_row(spq_pkg::CMD_ENQUEUE, -32'sd1, 1'b0, '0));
        directed_rows.push_back(make_row(spq_pkg::CMD_ENQUEUE, 32'sd7, 1'b0, '0));
        directed_rows.push_back(make_row(CMD_UNUSED, 32'sd7, 1'b0, '0));
        directed_rows.push_back(make_row(spq_pkg::CMD_DEQUEUE, 32'sd0, 1'b0, '0));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].rsp);

        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                send_idle_pct = 81;
                recv_idle_pct = 32;
            end
            else if (phase == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_pending  = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(random_request(((n / BIAS_STRETCH) % 2) == 0), 1'b0, '0);
        end

        @(negedge clk);
        req_valid <= 1'b0;

        while (pending_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* sorted_priority_queue_top.f */
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_top.sv
rtl/core/spq_checker.sv
tb/sv/sorted_priority_queue_top_tb.sv
